FILE: src/enc_ase_pkg.sv
package enc_ase_pkg;

  // Fixed-point format of angles and speed
  localparam int FRAC_BITS = 24;

  // Field and register widths
  localparam int POS_W     = 16;
  localparam int ANGLE_W   = 24;
  localparam int SPEED_W   = 32;
  localparam int MOD_W     = 17;
  localparam int OFF_W     = 16;
  localparam int PP_W      = 31;
  localparam int PRESC_W   = 16;
  localparam int ALPHA_W   = 25;
  localparam int GAIN_W    = 31;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;

  // Shared multiplier operand widths
  localparam int MUL_A_W = FRAC_BITS + 2;
  localparam int MUL_B_W = SPEED_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_MULT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd5;

  // Register reset values
  localparam logic [MOD_W-1:0]   MODULUS_RST       = 17'd65536;
  localparam logic [PRESC_W-1:0] PRESCALER_RST     = 16'd10;
  localparam logic [PRESC_W-1:0] DEFAULT_PRESCALER = 16'd10;
  localparam logic [ALPHA_W-1:0] ALPHA_RST         = 25'd14796018;

  // Multiplier operation select
  typedef logic [1:0] mul_op_t;
  localparam mul_op_t MUL_ELEC = 2'd0;
  localparam mul_op_t MUL_RAW  = 2'd1;
  localparam mul_op_t MUL_OLD  = 2'd2;
  localparam mul_op_t MUL_NEW  = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0] raw_position;
  } pos_word_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]        mech_angle;
    logic [ANGLE_W-1:0]        elec_angle;
    logic signed [SPEED_W-1:0] filtered_speed;
    logic                      speed_updated;
  } angle_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    accept;
    logic    mod_step;
    logic    norm_load;
    logic    div_step;
    mul_op_t mul_op;
    logic    elec_cap;
    logic    delta_load;
    logic    raw_cap;
    logic    old_cap;
    logic    new_cap;
    logic    speed_upd;
    logic    out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic due;
  } stat_t;

  // Saturate a wide signed value to the speed range
  function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-SPEED_W:0] upper;
    upper = v[PROD_W-1:SPEED_W-1];
    if ((&upper) || !(|upper)) begin
      sat_speed = v[SPEED_W-1:0];
    end else if (v[PROD_W-1]) begin
      sat_speed = {1'b1, {(SPEED_W-1){1'b0}}};
    end else begin
      sat_speed = {1'b0, {(SPEED_W-1){1'b1}}};
    end
  endfunction

  // Floor-shift a fixed-point product and saturate
  function automatic logic signed [SPEED_W-1:0] qmul_shift(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] sh;
    sh = p >>> FRAC_BITS;
    qmul_shift = sat_speed(sh);
  endfunction

endpackage

FILE: src/enc_ase_if.sv
interface enc_ase_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/enc_ase_ctrl.sv
module enc_ase_ctrl import enc_ase_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam int STEP_W = $clog2(FRAC_BITS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MOD  = 4'd1;
  localparam logic [3:0] S_NORM = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_MULE = 4'd4;
  localparam logic [3:0] S_WRAP = 4'd5;
  localparam logic [3:0] S_MULR = 4'd6;
  localparam logic [3:0] S_CAPR = 4'd7;
  localparam logic [3:0] S_CAPO = 4'd8;
  localparam logic [3:0] S_CAPN = 4'd9;
  localparam logic [3:0] S_SUM  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              out_valid_next;

  assign in_ready = (state == S_IDLE);

  // Sequence one word through remainder, divide and filter steps
  always_comb begin
    state_next     = state;
    step_next      = step;
    cmd            = '0;
    cmd.mul_op     = MUL_ELEC;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          step_next  = STEP_W'(POS_W - 1);
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        step_next    = step - 1'b1;
        if (step == '0) begin
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        cmd.norm_load = 1'b1;
        step_next     = STEP_W'(FRAC_BITS - 1);
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step - 1'b1;
        if (step == '0) begin
          state_next = S_MULE;
        end
      end
      S_MULE: begin
        cmd.mul_op = MUL_ELEC;
        state_next = S_WRAP;
      end
      S_WRAP: begin
        cmd.elec_cap   = 1'b1;
        cmd.delta_load = 1'b1;
        state_next     = stat.due ? S_MULR : S_OUT;
      end
      S_MULR: begin
        cmd.mul_op = MUL_RAW;
        state_next = S_CAPR;
      end
      S_CAPR: begin
        cmd.raw_cap = 1'b1;
        cmd.mul_op  = MUL_OLD;
        state_next  = S_CAPO;
      end
      S_CAPO: begin
        cmd.old_cap = 1'b1;
        cmd.mul_op  = MUL_NEW;
        state_next  = S_CAPN;
      end
      S_CAPN: begin
        cmd.new_cap = 1'b1;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.speed_upd = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold the result word until the sink takes it
  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: src/enc_ase_dp.sv
module enc_ase_dp import enc_ase_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  pos_word_t            in_data,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output angle_word_t          out_data
);

  localparam logic signed [MUL_A_W-1:0] ONE  = MUL_A_W'(1) <<< FRAC_BITS;
  localparam logic signed [MUL_A_W-1:0] HALF = MUL_A_W'(1) <<< (FRAC_BITS - 1);

  // Configuration registers
  logic [MOD_W-1:0]   modulus;
  logic [OFF_W-1:0]   offset;
  logic [PP_W-1:0]    pole_mult;
  logic [PRESC_W-1:0] prescaler;
  logic [ALPHA_W-1:0] alpha;
  logic [GAIN_W-1:0]  gain;

  // Item state
  logic [PRESC_W-1:0]        count;
  logic                      due;
  logic [FRAC_BITS-1:0]      prev;
  logic signed [SPEED_W-1:0] speed;

  // Working registers
  logic [POS_W-1:0]          pos_sh;
  logic [OFF_W-1:0]          off_sh;
  logic [MOD_W-1:0]          pos_rem;
  logic [MOD_W-1:0]          off_rem;
  logic [MOD_W-1:0]          rem;
  logic [FRAC_BITS-1:0]      quo;
  logic signed [PROD_W-1:0]  prod;
  logic [ANGLE_W-1:0]        elec;
  logic signed [MUL_A_W-1:0] delta;
  logic signed [SPEED_W-1:0] raw;
  logic signed [SPEED_W-1:0] a_old;
  logic signed [SPEED_W-1:0] a_new;

  logic                      mod_ok;
  logic [PRESC_W-1:0]        presc_eff;
  logic [PRESC_W-1:0]        count_inc;
  logic [MOD_W:0]            pos_try;
  logic [MOD_W:0]            off_try;
  logic [MOD_W:0]            div_try;
  logic                      div_bit;
  logic [MOD_W:0]            nsum;
  logic signed [MUL_A_W-1:0] dd;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [SPEED_W:0]   ssum;

  assign mod_ok    = (modulus >= MOD_W'(2));
  assign presc_eff = (prescaler == '0) ? DEFAULT_PRESCALER : prescaler;
  assign count_inc = count + 1'b1;
  assign stat.due  = due;

  assign pos_try = {pos_rem, pos_sh[POS_W-1]};
  assign off_try = {off_rem, off_sh[OFF_W-1]};
  assign div_try = {rem, 1'b0};
  assign div_bit = mod_ok && (div_try >= {1'b0, modulus});
  assign nsum    = {1'b0, pos_rem} + {1'b0, modulus} - {1'b0, off_rem};
  assign dd      = signed'(MUL_A_W'(quo)) - signed'(MUL_A_W'(prev));
  assign ssum    = {a_old[SPEED_W-1], a_old} + {a_new[SPEED_W-1], a_new};

  // Select multiplier operands
  always_comb begin
    unique case (cmd.mul_op)
      MUL_ELEC: begin
        mul_a = signed'(MUL_A_W'(quo));
        mul_b = signed'(MUL_B_W'(pole_mult));
      end
      MUL_RAW: begin
        mul_a = delta;
        mul_b = signed'(MUL_B_W'(gain));
      end
      MUL_OLD: begin
        mul_a = signed'(MUL_A_W'(alpha));
        mul_b = speed;
      end
      MUL_NEW: begin
        mul_a = ONE - signed'(MUL_A_W'(alpha));
        mul_b = raw;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus   <= MODULUS_RST;
      offset    <= '0;
      pole_mult <= '0;
      prescaler <= PRESCALER_RST;
      alpha     <= ALPHA_RST;
      gain      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS:   modulus   <= cfg_data[MOD_W-1:0];
        REG_OFFSET:    offset    <= cfg_data[OFF_W-1:0];
        REG_POLE_MULT: pole_mult <= cfg_data[PP_W-1:0];
        REG_PRESCALER: prescaler <= cfg_data[PRESC_W-1:0];
        REG_ALPHA:     alpha     <= cfg_data[ALPHA_W-1:0];
        REG_GAIN:      gain      <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Advance the prescaler count and the filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      due   <= 1'b0;
      prev  <= '0;
      speed <= '0;
    end else begin
      if (cmd.accept) begin
        due   <= (count_inc >= presc_eff);
        count <= (count_inc >= presc_eff) ? '0 : count_inc;
      end
      if (cmd.speed_upd) begin
        speed <= sat_speed(PROD_W'(ssum));
        prev  <= quo;
      end
    end
  end

  // Remainder, normalize and divide steps
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pos_sh  <= in_data.raw_position;
      off_sh  <= offset;
      pos_rem <= '0;
      off_rem <= '0;
    end
    if (cmd.mod_step) begin
      pos_sh <= pos_sh << 1;
      off_sh <= off_sh << 1;
      if (mod_ok && (pos_try >= {1'b0, modulus})) begin
        pos_rem <= MOD_W'(pos_try - {1'b0, modulus});
      end else begin
        pos_rem <= MOD_W'(pos_try);
      end
      if (mod_ok && (off_try >= {1'b0, modulus})) begin
        off_rem <= MOD_W'(off_try - {1'b0, modulus});
      end else begin
        off_rem <= MOD_W'(off_try);
      end
    end
    if (cmd.norm_load) begin
      quo <= '0;
      if (!mod_ok) begin
        rem <= '0;
      end else if (nsum >= {1'b0, modulus}) begin
        rem <= MOD_W'(nsum - {1'b0, modulus});
      end else begin
        rem <= MOD_W'(nsum);
      end
    end
    if (cmd.div_step) begin
      rem <= div_bit ? MOD_W'(div_try - {1'b0, modulus}) : MOD_W'(div_try);
      quo <= {quo[FRAC_BITS-2:0], div_bit};
    end
  end

  // Multiply and capture products
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (cmd.elec_cap) begin
      elec <= prod[FRAC_BITS +: ANGLE_W];
    end
    if (cmd.delta_load) begin
      if (dd > HALF) begin
        delta <= dd - ONE;
      end else if (dd < -HALF) begin
        delta <= dd + ONE;
      end else begin
        delta <= dd;
      end
    end
    if (cmd.raw_cap) begin
      raw <= qmul_shift(prod);
    end
    if (cmd.old_cap) begin
      a_old <= qmul_shift(prod);
    end
    if (cmd.new_cap) begin
      a_new <= qmul_shift(prod);
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.mech_angle     <= ANGLE_W'(quo);
      out_data.elec_angle     <= elec;
      out_data.filtered_speed <= speed;
      out_data.speed_updated  <= due;
    end
  end

endmodule

FILE: src/encoder_angle_speed_estimator.sv
// Each word passes through the bit-serial remainder loop (16 steps), a normalize step,
// the restoring divide loop (24 steps) and the electrical-angle multiply; a speed update
// adds the filter products. The next word is accepted only once the result word is loaded.
// A result word may wait in the output register while the next word is accepted.
// Reset (rst, synchronous): registers return to their defaults, count, speed and
// previous angle clear, no result is pending.
module encoder_angle_speed_estimator import enc_ase_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  enc_ase_if.sink              position,
  enc_ase_if.source            angle
);

  cmd_t        cmd;
  stat_t       stat;
  logic        in_ready;
  logic        out_valid;
  pos_word_t   in_data;
  angle_word_t out_data;

  assign position.ready = in_ready;
  assign angle.valid    = out_valid;
  assign in_data        = position.data;
  assign angle.data     = out_data;

  enc_ase_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (position.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (angle.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  enc_ase_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
